/* design/assert_macros.svh */
// Assertion macros shared by the circle trajectory generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* design/ctg_pkg.sv */
// Shared widths, types, register codes and the quarter-wave sine table.
// Depends on nothing; imported by every generator module except ctg_ram, and by the testbench.
package ctg_pkg;

    // Field and datapath widths
    localparam int PHASE_BITS     = 24;
    localparam int COORD_BITS     = 12;
    localparam int SINE_FRAC_BITS = 16;

    localparam int LUT_BITS   = 10;
    localparam int LUT_SIZE   = 1 << LUT_BITS;
    localparam int ROM_ADDR_W = LUT_BITS + 1;
    localparam int QW_W       = SINE_FRAC_BITS + 1;
    localparam int TRIG_W     = SINE_FRAC_BITS + 2;
    localparam int MUL_W      = COORD_BITS + SINE_FRAC_BITS + 3;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = PHASE_BITS;

    // Output queue and state memory geometry
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int ELAPSED_DEPTH = 1;
    localparam int ELAPSED_AW    = (ELAPSED_DEPTH > 1) ? $clog2(ELAPSED_DEPTH) : 1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_START_PHASE = 3'd3,
        CFG_PHASE_STEP  = 3'd4
    } cfg_index_t;

    // One result word; pos_x sits in the low bits
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_x;
    } point_t;

    typedef logic [QW_W-1:0] qw_entry_t;
    typedef qw_entry_t qw_table_t [LUT_SIZE+1];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine, Q30 Taylor series rounded to SINE_FRAC_BITS, elaboration only
    function automatic qw_table_t build_quarter_wave();
        qw_table_t       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        int              i;
        for (i = 0; i <= LUT_SIZE; i++)
        begin
            x    = (HALF_PI_Q30 * i) >> LUT_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 420; sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 506; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 600; sum = sum + longint'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            r = (longint'(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
            if (r > (64'd1 << SINE_FRAC_BITS))
            begin
                r = 64'd1 << SINE_FRAC_BITS;
            end
            tab[i] = r[QW_W-1:0];
        end
        return tab;
    endfunction

    localparam qw_table_t QUARTER_WAVE = build_quarter_wave();

endpackage

/* design/ctg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the elapsed-phase state of the generator.
module ctg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/ctg_sine_rom.sv */
// Dual-read quarter-wave sine ROM with registered outputs.
// Depends on ctg_pkg for the table contents and widths.
module ctg_sine_rom (
    input  logic                           clk,
    input  logic [ctg_pkg::ROM_ADDR_W-1:0] addr_a,
    input  logic [ctg_pkg::ROM_ADDR_W-1:0] addr_b,
    output logic [ctg_pkg::QW_W-1:0]       data_a,
    output logic [ctg_pkg::QW_W-1:0]       data_b
);
    import ctg_pkg::*;

    // Look up both angles every cycle
    always_ff @(posedge clk)
    begin
        data_a <= QUARTER_WAVE[addr_a];
        data_b <= QUARTER_WAVE[addr_b];
    end

endmodule

/* design/ctg_axis.sv */
// One coordinate axis: signed trig times radius, plus center, truncate, saturate.
// Depends on ctg_pkg; the product is registered, the sum is combinational.
module ctg_axis (
    input  logic                                  clk,
    input  logic [ctg_pkg::QW_W-1:0]              trig_mag,
    input  logic                                  trig_neg,
    input  logic [ctg_pkg::COORD_BITS-1:0]        radius,
    input  logic signed [ctg_pkg::COORD_BITS-1:0] center,
    output logic signed [ctg_pkg::COORD_BITS-1:0] pos
);
    import ctg_pkg::*;

    logic signed [TRIG_W-1:0]               trig;
    logic signed [MUL_W-1:0]                product_reg;
    logic signed [MUL_W-1:0]                center_scaled;
    logic signed [MUL_W-1:0]                total;
    logic signed [MUL_W-1:0]                total_adj;
    logic signed [MUL_W-SINE_FRAC_BITS-1:0] whole;
    logic                                   overflow;

    // Apply the quadrant sign to the table magnitude
    assign trig = trig_neg ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    // Multiply radius by the signed trig value
    always_ff @(posedge clk)
    begin
        product_reg <= $signed({1'b0, radius}) * trig;
    end

    // Add center, truncate toward zero to whole pixels, clamp to the coordinate range
    always_comb
    begin
        center_scaled = {{(MUL_W-COORD_BITS-SINE_FRAC_BITS){center[COORD_BITS-1]}},
                         center, {SINE_FRAC_BITS{1'b0}}};
        total     = product_reg + center_scaled;
        total_adj = total[MUL_W-1]
                  ? total + $signed({{(MUL_W-SINE_FRAC_BITS){1'b0}}, {SINE_FRAC_BITS{1'b1}}})
                  : total;
        whole     = total_adj[MUL_W-1:SINE_FRAC_BITS];
        overflow  = (whole[MUL_W-SINE_FRAC_BITS-1:COORD_BITS-1]
                     != {(MUL_W-SINE_FRAC_BITS-COORD_BITS+1){whole[MUL_W-SINE_FRAC_BITS-1]}});
        if (overflow)
        begin
            pos = whole[MUL_W-SINE_FRAC_BITS-1]
                ? $signed({1'b1, {(COORD_BITS-1){1'b0}}})
                : $signed({1'b0, {(COORD_BITS-1){1'b1}}});
        end
        else
        begin
            pos = whole[COORD_BITS-1:0];
        end
    end

endmodule

/* design/ctg_out_fifo.sv */
// Result queue between the fixed-latency pipeline and the output stream.
// Depends on ctg_pkg for the point type and queue geometry.
module ctg_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  ctg_pkg::point_t                push_data,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output ctg_pkg::point_t                pop_data,
    output logic [ctg_pkg::FIFO_CNT_W-1:0] count
);
    import ctg_pkg::*;

    point_t                entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store each finished word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/circle_trajectory_generator_top.sv */
// Circle trajectory generator: takes one tick word per cycle while s_axis_tready is
// high and returns one point per tick. Each word first adds phase_step to the elapsed
// phase when advance is set, then reports x = center_x + radius*cos, y = center_y +
// radius*sin at angle start_phase + elapsed, truncated toward zero and clamped to the
// signed coordinate range. Words are accepted back to back, one per cycle, while ready
// is high. The state memory is read at the accepting edge, followed in order by the
// angle register after the read-modify-write, the sine ROM read, the
// multiply register and the output queue. The elapsed phase lives in a one-entry
// synchronous RAM with forwarding of the previous write; an eight-word output queue
// absorbs downstream stalls, and the input stalls only when queued plus in-flight
// words fill it. No clearing pass is needed after reset. Configuration is to be
// written only while idle; the block itself does not enforce this.
// Depends on ctg_pkg, ctg_ram, ctg_sine_rom, ctg_axis, ctg_out_fifo, assert_macros.svh.
`include "assert_macros.svh"

module circle_trajectory_generator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_axis_tdata: [0] advance, upper bits zero
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ctg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // m_axis_tdata: [11:0] pos_x, [23:12] pos_y
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ctg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [ctg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ctg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ctg_pkg::*;

    // Configuration registers
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic [COORD_BITS-1:0]        radius_reg;
    logic [PHASE_BITS-1:0]        start_phase_reg;
    logic [PHASE_BITS-1:0]        phase_step_reg;

    // Pipeline control
    logic                  in_accept;
    logic                  s1_valid_reg;
    logic                  s1_adv_reg;
    logic                  s1_fwd_reg;
    logic                  s1_init_reg;
    logic                  s2_valid_reg;
    logic                  s3_valid_reg;
    logic                  s4_valid_reg;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] occupancy;

    // State memory and forwarding
    logic                  ram_valid_reg;
    logic                  ram_we;
    logic [PHASE_BITS-1:0] ram_rdata;
    logic [PHASE_BITS-1:0] last_wr_reg;
    logic [PHASE_BITS-1:0] elapsed_cur;
    logic [PHASE_BITS-1:0] elapsed_next;

    // Angle and table addressing
    logic [PHASE_BITS-1:0] s2_angle_reg;
    logic [1:0]            sin_quad;
    logic [1:0]            cos_quad;
    logic [LUT_BITS-1:0]   lut_idx;
    logic [ROM_ADDR_W-1:0] sin_addr;
    logic [ROM_ADDR_W-1:0] cos_addr;
    logic [QW_W-1:0]       sin_mag;
    logic [QW_W-1:0]       cos_mag;
    logic                  s3_sin_neg_reg;
    logic                  s3_cos_neg_reg;

    point_t                result;
    point_t                head;

    // Input handshake
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign occupancy     = fifo_count + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg)
                         + FIFO_CNT_W'(s3_valid_reg) + FIFO_CNT_W'(s4_valid_reg);
    assign s_axis_tready = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_reg      <= '0;
            start_phase_reg <= '0;
            phase_step_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:    center_x_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:      radius_reg      <= cfg_data[COORD_BITS-1:0];
                CFG_START_PHASE: start_phase_reg <= cfg_data[PHASE_BITS-1:0];
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[PHASE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Elapsed-phase state memory
    ctg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (ELAPSED_DEPTH)
    ) u_elapsed_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ('0),
        .wdata (elapsed_next),
        .re    (in_accept),
        .raddr ('0),
        .rdata (ram_rdata)
    );

    // Read-modify-write: take the forwarded write when it landed at the read edge
    assign ram_we = s1_valid_reg;

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            elapsed_cur = last_wr_reg;
        end
        else if (s1_init_reg)
        begin
            elapsed_cur = ram_rdata;
        end
        else
        begin
            elapsed_cur = '0;
        end
        elapsed_next = s1_adv_reg ? elapsed_cur + phase_step_reg : elapsed_cur;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            last_wr_reg <= elapsed_next;
        end
        s2_angle_reg <= start_phase_reg + elapsed_next;
    end

    // Table addresses; cosine is one quadrant ahead
    always_comb
    begin
        sin_quad = s2_angle_reg[PHASE_BITS-1 -: 2];
        cos_quad = sin_quad + 2'd1;
        lut_idx  = s2_angle_reg[PHASE_BITS-3 -: LUT_BITS];
        sin_addr = sin_quad[0] ? ROM_ADDR_W'(LUT_SIZE) - {1'b0, lut_idx} : {1'b0, lut_idx};
        cos_addr = cos_quad[0] ? ROM_ADDR_W'(LUT_SIZE) - {1'b0, lut_idx} : {1'b0, lut_idx};
    end

    ctg_sine_rom u_sine_rom (
        .clk    (clk),
        .addr_a (cos_addr),
        .addr_b (sin_addr),
        .data_a (cos_mag),
        .data_b (sin_mag)
    );

    always_ff @(posedge clk)
    begin
        s3_sin_neg_reg <= sin_quad[1];
        s3_cos_neg_reg <= cos_quad[1];
    end

    // Per-axis multiply and saturate
    ctg_axis u_axis_x (
        .clk      (clk),
        .trig_mag (cos_mag),
        .trig_neg (s3_cos_neg_reg),
        .radius   (radius_reg),
        .center   (center_x_reg),
        .pos      (result.pos_x)
    );

    ctg_axis u_axis_y (
        .clk      (clk),
        .trig_mag (sin_mag),
        .trig_neg (s3_sin_neg_reg),
        .radius   (radius_reg),
        .center   (center_y_reg),
        .pos      (result.pos_y)
    );

    // Advance valid bits and the state-memory bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_adv_reg    <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            s1_init_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            ram_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                s1_adv_reg  <= s_axis_tdata[0];
                s1_fwd_reg  <= ram_we;
                s1_init_reg <= ram_valid_reg;
            end
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (ram_we)
            begin
                ram_valid_reg <= 1'b1;
            end
        end
    end

    // Output queue
    ctg_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_valid_reg),
        .push_data (result),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (head),
        .count     (fifo_count)
    );

    assign m_axis_tdata = OUT_TDATA_W'(head);

    // Queue plus in-flight words never exceed the queue depth
    `CTG_ASSERT_NOW(a_occupancy_bound, clk, rst_n, 1'b1, occupancy <= FIFO_CNT_W'(FIFO_DEPTH))
    // A finished word never meets a full queue
    `CTG_ASSERT_NOW(a_no_push_full, clk, rst_n, s4_valid_reg,
                    fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
    // Forwarding is used only when the state memory was written at the read edge
    `CTG_ASSERT_NOW(a_fwd_source, clk, rst_n, s1_valid_reg && s1_fwd_reg, $past(ram_we))
    // Every accepted word reaches the output stage, s4_valid_reg, after passing s1, s2 and s3
    `CTG_ASSERT_NEXT(a_latency, clk, rst_n, in_accept, ##3 s4_valid_reg)

endmodule

/* tb/sv/circle_trajectory_generator_top_tb.sv */
// Self-checking testbench for circle_trajectory_generator_top: tick words in, circle points out.
// Builds its own quarter-wave sine table and tracks the elapsed phase to predict every point.
// Depends on ctg_pkg and the generator RTL only.
`timescale 1ns / 100ps

module circle_trajectory_generator_top_tb;

    import ctg_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int HOLD_STRETCH  = 150;
    localparam int RANDOM_TICKS  = 1200;
    localparam int PRINT_CAP     = 100;
    localparam int REG_COUNT     = int'(CFG_PHASE_STEP) + 1;

    localparam logic [PHASE_BITS-1:0] QUARTER_TURN       = 1 << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] HALF_TURN          = 1 << (PHASE_BITS - 1);
    localparam logic [PHASE_BITS-1:0] THREE_QUARTER_TURN = 3 << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] LAST_PHASE         = {PHASE_BITS{1'b1}};

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted block state and register copies
    int                    track_center_x;
    int                    track_center_y;
    int                    track_radius;
    logic [PHASE_BITS-1:0] track_start;
    logic [PHASE_BITS-1:0] track_step;
    logic [PHASE_BITS-1:0] track_elapsed;
    longint                sine_table [0:LUT_SIZE];

    point_t expected_points [$];
    int     mismatch_count;
    int     stuck_cycles;
    int     sink_hold_cycles;
    bit     src_idle_en;
    bit     sink_idle_en;

    circle_trajectory_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] advance, upper bits zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [11:0] pos_x, [23:12] pos_y
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Count cycles without any input or output handshake; give up at the limit
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[circle_trajectory_generator_top] ERROR");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count = mismatch_count + 1;
        // keep the log short on a badly broken block
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Quarter-wave sine in Q30, rounded to SINE_FRAC_BITS and capped at one
    function automatic void fill_sine_table();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        int              i;
        int              n;
        for (i = 0; i <= LUT_SIZE; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) >> LUT_BITS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            r = (longint'(acc) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
            if (r > (64'd1 << SINE_FRAC_BITS))
            begin
                r = 64'd1 << SINE_FRAC_BITS;
            end
            sine_table[i] = longint'(r);
        end
    endfunction

    // Signed sine of a phase word: top bits pick quadrant and table entry
    function automatic longint wave_q16(input logic [PHASE_BITS-1:0] ang);
        logic [LUT_BITS+1:0] top;
        int                  idx;
        longint              s;
        top = ang[PHASE_BITS-1 -: LUT_BITS + 2];
        idx = int'(top[LUT_BITS-1:0]);
        if (top[LUT_BITS])
        begin
            idx = LUT_SIZE - idx;
        end
        s = sine_table[idx];
        return top[LUT_BITS+1] ? -s : s;
    endfunction

    // center + radius*trig, truncated toward zero, clamped to the coordinate range
    function automatic logic [COORD_BITS-1:0] axis_pixel(input int center, input longint trig);
        longint total;
        longint whole;
        longint hi;
        longint lo;
        total = longint'(center) * (longint'(1) << SINE_FRAC_BITS)
                + longint'(track_radius) * trig;
        if (total < 0)
        begin
            whole = -((-total) >>> SINE_FRAC_BITS);
        end
        else
        begin
            whole = total >>> SINE_FRAC_BITS;
        end
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (whole > hi)
        begin
            whole = hi;
        end
        if (whole < lo)
        begin
            whole = lo;
        end
        return whole[COORD_BITS-1:0];
    endfunction

    // Write one register while idle and mirror it into the predictor
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_X:    track_center_x = $signed(value[COORD_BITS-1:0]);
            CFG_CENTER_Y:    track_center_y = $signed(value[COORD_BITS-1:0]);
            CFG_RADIUS:      track_radius   = int'(value[COORD_BITS-1:0]);
            CFG_START_PHASE: track_start    = value[PHASE_BITS-1:0];
            CFG_PHASE_STEP:  track_step     = value[PHASE_BITS-1:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // Offer one tick word, after a random gap when source idling is on; predict its point once accepted
    task automatic send_tick(input logic adv);
        int                    gap;
        logic [PHASE_BITS-1:0] ang;
        point_t                p;
        gap = src_idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(adv);
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (adv)
        begin
            track_elapsed = track_elapsed + track_step;
        end
        ang     = track_start + track_elapsed;
        p.pos_x = axis_pixel(track_center_x, wave_q16(ang + QUARTER_TURN));
        p.pos_y = axis_pixel(track_center_y, wave_q16(ang));
        expected_points.push_back(p);
    endtask

    // Stop offering and hold until every predicted point has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register value: extremes now and then, otherwise random; bits above width random
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] pick;
        mask = (CFG_DATA_W'(1) << width) - 1;
        if (width == CFG_DATA_W)
        begin
            mask = '1;
        end
        case ($urandom_range(0, 9))
            0: pick = '1;
            1: pick = CFG_DATA_W'(1) << (width - 1);
            2: pick = (CFG_DATA_W'(1) << (width - 1)) - 1;
            3: pick = '0;
            4: pick = CFG_DATA_W'($urandom_range(1, 4096));
            5: pick = -CFG_DATA_W'($urandom_range(1, 4096));
            default: pick = CFG_DATA_W'($urandom());
        endcase
        return (CFG_DATA_W'($urandom()) & ~mask) | (pick & mask);
    endfunction

    // Return points for every accepted word and compare with the oldest prediction
    initial
    begin : point_sink
        int     stall;
        point_t got;
        point_t want;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            stall = sink_idle_en ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            got = point_t'(m_axis_tdata[2*COORD_BITS-1:0]);
            if (expected_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected point x=%0d y=%0d",
                                          got.pos_x, got.pos_y));
            end
            else
            begin
                want = expected_points.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
                end
                if (got.pos_y !== want.pos_y)
                begin
                    report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
                end
            end
        end
    end

    // After reset: zero radius and center, points sit at the origin
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Largest radius at each quadrant boundary; phase zero and the half turn drive the x axis into saturation
    task automatic test_extreme_points();
        write_reg(CFG_CENTER_X, CFG_DATA_W'(2047));
        write_reg(CFG_CENTER_Y, -CFG_DATA_W'(2048));
        write_reg(CFG_RADIUS, CFG_DATA_W'(4095));
        write_reg(CFG_PHASE_STEP, '0);
        write_reg(CFG_START_PHASE, '0);
        send_tick(1'b0);
        wait_idle();
        write_reg(CFG_START_PHASE, QUARTER_TURN);
        send_tick(1'b0);
        wait_idle();
        write_reg(CFG_CENTER_X, -CFG_DATA_W'(2048));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(2047));
        write_reg(CFG_START_PHASE, HALF_TURN);
        send_tick(1'b0);
        wait_idle();
        write_reg(CFG_START_PHASE, THREE_QUARTER_TURN);
        send_tick(1'b1);
        wait_idle();
        write_reg(CFG_START_PHASE, LAST_PHASE);
        send_tick(1'b0);
        wait_idle();
    endtask

    // Negative fractions must truncate toward zero, not down
    task automatic test_truncation();
        write_reg(CFG_CENTER_X, '0);
        write_reg(CFG_CENTER_Y, '0);
        write_reg(CFG_RADIUS, CFG_DATA_W'(1));
        write_reg(CFG_START_PHASE, HALF_TURN + (QUARTER_TURN >> 2));
        send_tick(1'b0);
        wait_idle();
        write_reg(CFG_RADIUS, CFG_DATA_W'(3));
        write_reg(CFG_START_PHASE, HALF_TURN + (QUARTER_TURN >> 1));
        send_tick(1'b0);
        wait_idle();
    endtask

    // Bits above a register's width and indexes past the list are ignored
    task automatic test_register_masking();
        write_reg(CFG_RADIUS, CFG_DATA_W'(24'hABC005));
        write_reg(CFG_CENTER_X, CFG_DATA_W'(24'h5A5F00));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(24'hF0F0FF));
        for (int k = REG_COUNT; k < (1 << CFG_INDEX_W); k++)
        begin
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom()));
        end
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Half-turn-sized steps wrap the elapsed phase; a unit step follows
    task automatic test_step_wrap();
        write_reg(CFG_RADIUS, CFG_DATA_W'(1000));
        write_reg(CFG_START_PHASE, CFG_DATA_W'(12345));
        write_reg(CFG_PHASE_STEP, HALF_TURN);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
        write_reg(CFG_PHASE_STEP, HALF_TURN - 1);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
        write_reg(CFG_PHASE_STEP, CFG_DATA_W'(1));
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
    endtask

    // Hold the output long enough to fill the queue and stall the input
    task automatic test_backpressure();
        src_idle_en      = 1'b0;
        sink_idle_en     = 1'b0;
        write_reg(CFG_PHASE_STEP, CFG_DATA_W'(40000));
        sink_hold_cycles = HOLD_STRETCH;
        repeat (40) send_tick($urandom_range(0, 3) != 0);
        wait_idle();
    endtask

    // Random settings per run, mostly advancing ticks, random idling per run
    task automatic test_random_circles();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            wait_idle();
            src_idle_en  = $urandom_range(0, 3) != 0;
            sink_idle_en = $urandom_range(0, 3) != 0;
            write_reg(CFG_CENTER_X, pick_reg_value(COORD_BITS));
            write_reg(CFG_CENTER_Y, pick_reg_value(COORD_BITS));
            write_reg(CFG_RADIUS, pick_reg_value(COORD_BITS));
            write_reg(CFG_START_PHASE, pick_reg_value(PHASE_BITS));
            write_reg(CFG_PHASE_STEP, pick_reg_value(PHASE_BITS));
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1)),
                          CFG_DATA_W'($urandom()));
            end
            n = $urandom_range(10, 80);
            repeat (n) send_tick($urandom_range(0, 3) != 0);
            sent = sent + n;
        end
        wait_idle();
    endtask

    initial
    begin : run
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        mismatch_count   = 0;
        stuck_cycles     = 0;
        sink_hold_cycles = 0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;
        track_center_x   = 0;
        track_center_y   = 0;
        track_radius     = 0;
        track_start      = '0;
        track_step       = '0;
        track_elapsed    = '0;
        fill_sine_table();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_points();
        test_truncation();
        test_register_masking();
        test_step_wrap();
        test_backpressure();
        test_random_circles();

        if (mismatch_count == 0)
        begin
            $display("[circle_trajectory_generator_top] OK");
        end
        else
        begin
            $display("[circle_trajectory_generator_top] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ctg_pkg.sv
design/ctg_ram.sv
design/ctg_sine_rom.sv
design/ctg_axis.sv
design/ctg_out_fifo.sv
design/circle_trajectory_generator_top.sv
tb/sv/circle_trajectory_generator_top_tb.sv
